// ===== src/rcfd_pkg.sv =====
// ----------------------------------------------------------------------------
// rcfd_pkg
// shared types, codes and the crc-8 byte update of the frame deframer
// ----------------------------------------------------------------------------
package rcfd_pkg;

    localparam int HEADER_BYTES = 5;
    localparam logic [9:0] POS_MAX = 10'h3FF;

    localparam logic [7:0] CRC_POLY = 8'h07;

    localparam logic [2:0] HDR_MAGIC = 3'd0;
    localparam logic [2:0] HDR_TYPE  = 3'd1;
    localparam logic [2:0] HDR_SEQ   = 3'd2;
    localparam logic [2:0] HDR_FLAGS = 3'd3;
    localparam logic [2:0] HDR_COUNT = 3'd4;

    localparam logic [2:0] CFG_MAGIC   = 3'd0;
    localparam logic [2:0] CFG_TYPE_CT = 3'd1;
    localparam logic [2:0] CFG_TYPE_ST = 3'd2;
    localparam logic [2:0] CFG_TYPE_PR = 3'd3;
    localparam logic [2:0] CFG_LIMIT   = 3'd4;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_SHORT = 2'd1;
    localparam logic [1:0] STS_CRC   = 2'd2;
    localparam logic [1:0] STS_BAD   = 2'd3;

    typedef enum logic [1:0] {
        ST_RECV,
        ST_READ,
        ST_SHOW
    } state_t;

    typedef struct packed {
        logic take;
        logic read;
        logic advance;
    } cmd_t;

    typedef struct packed {
        logic single;
        logic words;
        logic last;
    } sts_t;

    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== src/rcfd_ram.sv =====
// ----------------------------------------------------------------------------
// rcfd_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module rcfd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/rcfd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rcfd_ctrl
// controller: byte intake, word readout and result handshake
// ----------------------------------------------------------------------------
module rcfd_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  rcfd_pkg::sts_t sts,
    output rcfd_pkg::cmd_t cmd
);

    rcfd_pkg::state_t state_reg;
    rcfd_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rcfd_pkg::ST_RECV;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rcfd_pkg::ST_RECV: begin
                if (s_tvalid && sts.words) begin
                    state_next = rcfd_pkg::ST_READ;
                end else if (s_tvalid && sts.single) begin
                    state_next = rcfd_pkg::ST_SHOW;
                end
            end
            rcfd_pkg::ST_READ: begin
                state_next = rcfd_pkg::ST_SHOW;
            end
            rcfd_pkg::ST_SHOW: begin
                if (m_tready) begin
                    state_next = sts.last ? rcfd_pkg::ST_RECV : rcfd_pkg::ST_READ;
                end
            end
            default: begin
                state_next = rcfd_pkg::ST_RECV;
            end
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        m_tvalid    = 1'b0;
        cmd.take    = 1'b0;
        cmd.read    = 1'b0;
        cmd.advance = 1'b0;
        case (state_reg)
            rcfd_pkg::ST_RECV: begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
            end
            rcfd_pkg::ST_READ: begin
                cmd.read = 1'b1;
            end
            rcfd_pkg::ST_SHOW: begin
                m_tvalid    = 1'b1;
                cmd.advance = m_tready && !sts.last;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ===== src/rcfd_datapath.sv =====
// ----------------------------------------------------------------------------
// rcfd_datapath
// crc, header capture, word buffer, checks and result registers
// ----------------------------------------------------------------------------
module rcfd_datapath #(
    parameter int MAX_WORDS = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic [2:0]     cfg_addr,
    input  logic [7:0]     cfg_wr_data,
    input  logic [7:0]     rx_byte,
    input  logic           frame_start,
    input  logic           buffer_end,
    input  rcfd_pkg::cmd_t cmd,
    output rcfd_pkg::sts_t sts,
    output logic [1:0]     status,
    output logic [7:0]     frame_kind,
    output logic [7:0]     sequence_res,
    output logic [7:0]     flag_bits,
    output logic [4:0]     word_count,
    output logic           has_word,
    output logic [3:0]     word_index,
    output logic [15:0]    word_value
);

    localparam int IW = $clog2(MAX_WORDS);
    localparam logic [9:0] HDR_LEN = 10'(rcfd_pkg::HEADER_BYTES);

    logic [7:0]  magic_cfg_reg;
    logic [7:0]  type_ct_reg;
    logic [7:0]  type_st_reg;
    logic [7:0]  type_pr_reg;
    logic [4:0]  limit_cfg_reg;

    logic [9:0]  pos_reg;
    logic [7:0]  crc_reg;
    logic [7:0]  magic_reg;
    logic [7:0]  type_reg;
    logic [7:0]  seq_reg;
    logic [7:0]  flags_reg;
    logic [7:0]  count_reg;
    logic [7:0]  low_reg;
    logic        done_reg;

    logic [1:0]  out_status_reg;
    logic [7:0]  out_kind_reg;
    logic [7:0]  out_seq_reg;
    logic [7:0]  out_flags_reg;
    logic [4:0]  out_count_reg;
    logic        out_has_reg;
    logic [IW-1:0] idx_reg;

    logic [9:0]  p;
    logic [7:0]  crc_cur;
    logic [7:0]  crc_new;
    logic        active;
    logic        at_end;
    logic        finish;
    logic        proc;
    logic [9:0]  end_pos;
    logic [9:0]  off;
    logic [8:0]  widx;
    logic        store_en;
    logic [5:0]  limit;
    logic        crc_bad;
    logic        hdr_bad;
    logic        good_words;
    logic        single_ev;
    logic [1:0]  single_status;
    logic [15:0] rd_data;

    always_comb begin
        p          = frame_start ? 10'd0 : pos_reg;
        crc_cur    = frame_start ? 8'd0 : crc_reg;
        crc_new    = rcfd_pkg::crc8_next(crc_cur, rx_byte);
        active     = frame_start || !done_reg;
        end_pos    = HDR_LEN + {1'b0, count_reg, 1'b0};
        at_end     = (p >= HDR_LEN) && (p == end_pos);
        finish     = active && at_end;
        proc       = active && !at_end;
        off        = p - HDR_LEN;
        widx       = off[9:1];
        store_en   = cmd.take && proc && (p >= HDR_LEN) && off[0]
                     && (widx < 9'(MAX_WORDS));
        limit      = (6'(limit_cfg_reg) > 6'(MAX_WORDS)) ? 6'(MAX_WORDS)
                                                          : 6'(limit_cfg_reg);
        crc_bad    = crc_cur != rx_byte;
        hdr_bad    = (magic_reg != magic_cfg_reg)
                     || ((type_reg != type_ct_reg) && (type_reg != type_st_reg)
                         && (type_reg != type_pr_reg))
                     || (count_reg > 8'(limit));
        good_words = finish && !crc_bad && !hdr_bad && (count_reg != 8'd0);
        single_ev  = (finish && !good_words) || (proc && buffer_end);
        if (proc) begin
            single_status = rcfd_pkg::STS_SHORT;
        end else if (crc_bad) begin
            single_status = rcfd_pkg::STS_CRC;
        end else if (hdr_bad) begin
            single_status = rcfd_pkg::STS_BAD;
        end else begin
            single_status = rcfd_pkg::STS_OK;
        end
    end

    assign sts.single = cmd.take && single_ev;
    assign sts.words  = cmd.take && good_words;
    assign sts.last   = !out_has_reg || ((8'(idx_reg) + 8'd1) == count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_cfg_reg <= 8'd0;
            type_ct_reg   <= 8'd0;
            type_st_reg   <= 8'd1;
            type_pr_reg   <= 8'd2;
            limit_cfg_reg <= 5'd16;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                rcfd_pkg::CFG_MAGIC:   magic_cfg_reg <= cfg_wr_data;
                rcfd_pkg::CFG_TYPE_CT: type_ct_reg   <= cfg_wr_data;
                rcfd_pkg::CFG_TYPE_ST: type_st_reg   <= cfg_wr_data;
                rcfd_pkg::CFG_TYPE_PR: type_pr_reg   <= cfg_wr_data;
                rcfd_pkg::CFG_LIMIT:   limit_cfg_reg <= cfg_wr_data[4:0];
                default: begin
                end
            endcase
        end
    end

    // a frame start always lands in the proc branch, with p and crc_cur at zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= 10'd0;
            crc_reg   <= 8'd0;
            magic_reg <= 8'd0;
            type_reg  <= 8'd0;
            seq_reg   <= 8'd0;
            flags_reg <= 8'd0;
            count_reg <= 8'd0;
            low_reg   <= 8'd0;
            done_reg  <= 1'b1;
        end else if (cmd.take) begin
            if (finish) begin
                done_reg <= 1'b1;
            end else if (proc) begin
                crc_reg <= crc_new;
                if (p < HDR_LEN) begin
                    case (p[2:0])
                        rcfd_pkg::HDR_MAGIC: magic_reg <= rx_byte;
                        rcfd_pkg::HDR_TYPE:  type_reg  <= rx_byte;
                        rcfd_pkg::HDR_SEQ:   seq_reg   <= rx_byte;
                        rcfd_pkg::HDR_FLAGS: flags_reg <= rx_byte;
                        default:             count_reg <= rx_byte;
                    endcase
                end else if (!off[0]) begin
                    low_reg <= rx_byte;
                end
                pos_reg  <= (p < rcfd_pkg::POS_MAX) ? p + 10'd1 : p;
                done_reg <= buffer_end;
            end
        end
    end

    // result registers
    always_ff @(posedge aclk) begin
        if (sts.single) begin
            out_status_reg <= single_status;
            out_has_reg    <= 1'b0;
            idx_reg        <= '0;
            out_count_reg  <= 5'd0;
            if (finish && !crc_bad && !hdr_bad) begin
                out_kind_reg  <= type_reg;
                out_seq_reg   <= seq_reg;
                out_flags_reg <= flags_reg;
            end else begin
                out_kind_reg  <= 8'd0;
                out_seq_reg   <= 8'd0;
                out_flags_reg <= 8'd0;
            end
        end else if (sts.words) begin
            out_status_reg <= rcfd_pkg::STS_OK;
            out_has_reg    <= 1'b1;
            idx_reg        <= '0;
            out_count_reg  <= count_reg[4:0];
            out_kind_reg   <= type_reg;
            out_seq_reg    <= seq_reg;
            out_flags_reg  <= flags_reg;
        end else if (cmd.advance) begin
            idx_reg <= idx_reg + IW'(1);
        end
    end

    rcfd_ram #(
        .WIDTH(16),
        .DEPTH(MAX_WORDS)
    ) u_word_ram (
        .aclk    (aclk),
        .wr_en   (store_en),
        .wr_addr (widx[IW-1:0]),
        .wr_data ({rx_byte, low_reg}),
        .rd_en   (cmd.read),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    assign status       = out_status_reg;
    assign frame_kind   = out_kind_reg;
    assign sequence_res = out_seq_reg;
    assign flag_bits    = out_flags_reg;
    assign word_count   = out_count_reg;
    assign has_word     = out_has_reg;
    assign word_index   = 4'(idx_reg);
    assign word_value   = out_has_reg ? rd_data : 16'd0;

endmodule

// ===== src/rc_frame_crc8_deframer.sv =====
// ----------------------------------------------------------------------------
// rc_frame_crc8_deframer
// crc-8 checked frame deframer with buffered 16-bit channel words
// ----------------------------------------------------------------------------
// the slave channel takes one frame byte per request: tdata is the byte,
// tuser marks offset zero of a new frame, tlast marks the end of the buffer.
// header and channel bytes are stored as they are taken. the crc byte ends
// the frame, or a tlast byte cuts it short, and a single result (error, short
// buffer or empty frame) follows in the next cycle. a good frame gives one
// result per channel word, each read from the word ram in turn (ram read,
// then output register), and holds the slave side until its last word is
// taken. s_tready is low while results are out; a stalled master side holds
// the output register and with it the whole block.
// reset clears the controller, restores the register defaults and leaves the
// block idle: bytes are ignored until one with a frame start arrives.
// configuration registers are written through cfg_wr_en, cfg_addr and
// cfg_wr_data: 0 magic, 1 control type, 2 status type, 3 pairing type,
// 4 channel limit.
// ----------------------------------------------------------------------------
module rc_frame_crc8_deframer #(
    parameter int MAX_WORDS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    input  logic [0:0]  s_tuser,   // frame_start
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // frame_kind, sequence_res, flag_bits, word_count, word_index, word_value
    output logic [55:0] m_tdata,
    output logic [2:0]  m_tuser,   // status, has_word
    output logic        m_tlast
);

    rcfd_pkg::cmd_t cmd;
    rcfd_pkg::sts_t sts;

    logic [1:0]  status;
    logic [7:0]  frame_kind;
    logic [7:0]  sequence_res;
    logic [7:0]  flag_bits;
    logic [4:0]  word_count;
    logic        has_word;
    logic [3:0]  word_index;
    logic [15:0] word_value;

    rcfd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rcfd_datapath #(
        .MAX_WORDS(MAX_WORDS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wr_data  (cfg_wr_data),
        .rx_byte      (s_tdata),
        .frame_start  (s_tuser[0]),
        .buffer_end   (s_tlast),
        .cmd          (cmd),
        .sts          (sts),
        .status       (status),
        .frame_kind   (frame_kind),
        .sequence_res (sequence_res),
        .flag_bits    (flag_bits),
        .word_count   (word_count),
        .has_word     (has_word),
        .word_index   (word_index),
        .word_value   (word_value)
    );

    assign m_tdata = {7'd0, word_value, word_index, word_count,
                      flag_bits, sequence_res, frame_kind};
    assign m_tuser = {has_word, status};
    assign m_tlast = sts.last;

endmodule

// ===== dv/rc_frame_crc8_deframer_test.sv =====
// ----------------------------------------------------------------------------
// rc_frame_crc8_deframer_test
// self-checking bench for the crc-8 frame deframer
// ----------------------------------------------------------------------------
// frame bytes are queued per frame by an initial block and sent by a clocked
// driver; a clocked monitor decodes every accepted byte in its own copy of
// the deframer and checks each result request against the oldest prediction.
// several register settings are used, with random gaps on both sides, a
// long hold-off on the result side, and mostly well-formed frames mixed
// with bad crc, bad header, short, abandoned and stray bytes.
// ----------------------------------------------------------------------------
module rc_frame_crc8_deframer_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_SLOTS = 16;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
        logic       fin;
    } rx_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  kind;
        logic [7:0]  seq;
        logic [7:0]  flags;
        logic [4:0]  count;
        logic        has;
        logic [3:0]  idx;
        logic [15:0] value;
        logic        last;
    } frame_res_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_addr;
    logic [7:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // rx_byte
    logic [0:0]  s_tuser;   // frame_start
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    // frame_kind, sequence_res, flag_bits, word_count, word_index, word_value
    logic [55:0] m_tdata;
    logic [2:0]  m_tuser;   // status, has_word
    logic        m_tlast;

    rc_frame_crc8_deframer u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    rx_item_t   rx_due[$];
    frame_res_t results_due[$];

    int  bytes_queued = 0;
    int  bytes_taken = 0;
    int  framed_bytes = 0;
    int  frames_built = 0;
    int  results_checked = 0;
    int  errors = 0;
    int  quiet_cycles = 0;
    int  send_gap = 0;
    int  rx_stall = 0;
    int  hold_left = 0;
    int  hold_req = 0;
    int  hold_seen = 0;
    bit  steady = 0;
    bit  s_fire = 0;

    // deframer copy: registers
    logic [7:0] cfg_magic = 8'd0;
    logic [7:0] cfg_type_ct = 8'd0;
    logic [7:0] cfg_type_st = 8'd1;
    logic [7:0] cfg_type_pr = 8'd2;
    logic [4:0] cfg_limit = 5'd16;

    // deframer copy: frame state
    logic [9:0]  pos = '0;
    logic [7:0]  crc = '0;
    logic [7:0]  h_magic = '0;
    logic [7:0]  h_type = '0;
    logic [7:0]  h_seq = '0;
    logic [7:0]  h_flags = '0;
    logic [7:0]  h_count = '0;
    logic [7:0]  low_hold = '0;
    logic [15:0] words[WORD_SLOTS];
    bit          idle = 1;

    always #2 aclk = ~aclk;

    function automatic logic [7:0] crc_after(input logic [7:0] c, input logic [7:0] data);
        logic [7:0] r;
        logic       fb;
        r = c;
        for (int i = 7; i >= 0; i--) begin
            fb = r[7] ^ data[i];
            r = {r[6:0], 1'b0} ^ (fb ? rcfd_pkg::CRC_POLY : 8'h00);
        end
        return r;
    endfunction

    function automatic frame_res_t make_res(input logic [1:0] status, input logic [7:0] kind,
                                            input logic [7:0] seq, input logic [7:0] flags,
                                            input logic [4:0] count, input logic has,
                                            input logic [3:0] idx, input logic [15:0] value,
                                            input logic last);
        frame_res_t r;
        r.status = status;
        r.kind = kind;
        r.seq = seq;
        r.flags = flags;
        r.count = count;
        r.has = has;
        r.idx = idx;
        r.value = value;
        r.last = last;
        return r;
    endfunction

    function automatic int eff_limit();
        return (cfg_limit > WORD_SLOTS) ? WORD_SLOTS : int'(cfg_limit);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic deframe_byte(input logic [7:0] data, input logic start, input logic fin);
        int     off;
        logic   type_ok;
        if (start) begin
            pos = '0;
            crc = '0;
            idle = 0;
        end
        if (idle) return;
        if (pos >= rcfd_pkg::HEADER_BYTES && pos == rcfd_pkg::HEADER_BYTES + 2 * h_count) begin
            idle = 1;
            type_ok = (h_type == cfg_type_ct) || (h_type == cfg_type_st) ||
                      (h_type == cfg_type_pr);
            if (crc != data) begin
                results_due.push_back(make_res(rcfd_pkg::STS_CRC, 0, 0, 0, 0, 0, 0, 0, 1));
            end else if (h_magic != cfg_magic || !type_ok || h_count > eff_limit()) begin
                results_due.push_back(make_res(rcfd_pkg::STS_BAD, 0, 0, 0, 0, 0, 0, 0, 1));
            end else if (h_count == 0) begin
                results_due.push_back(make_res(rcfd_pkg::STS_OK, h_type, h_seq, h_flags,
                                               0, 0, 0, 0, 1));
            end else begin
                for (int i = 0; i < h_count; i++) begin
                    results_due.push_back(make_res(rcfd_pkg::STS_OK, h_type, h_seq, h_flags,
                                                   h_count[4:0], 1, i[3:0], words[i],
                                                   (i + 1 == h_count)));
                end
            end
            return;
        end
        crc = crc_after(crc, data);
        if (pos < rcfd_pkg::HEADER_BYTES) begin
            case (pos[2:0])
                rcfd_pkg::HDR_MAGIC: h_magic = data;
                rcfd_pkg::HDR_TYPE:  h_type = data;
                rcfd_pkg::HDR_SEQ:   h_seq = data;
                rcfd_pkg::HDR_FLAGS: h_flags = data;
                default:             h_count = data;
            endcase
        end else begin
            off = pos - rcfd_pkg::HEADER_BYTES;
            if (off % 2 == 0) begin
                low_hold = data;
            end else if (off / 2 < WORD_SLOTS) begin
                words[off / 2] = {data, low_hold};
            end
        end
        if (pos != rcfd_pkg::POS_MAX) pos = pos + 1'b1;
        if (fin) begin
            idle = 1;
            results_due.push_back(make_res(rcfd_pkg::STS_SHORT, 0, 0, 0, 0, 0, 0, 0, 1));
        end
    endtask

    task automatic report_mismatch(input string what, input int unsigned seen,
                                   input int unsigned want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, seen, want, $realtime);
        errors++;
    endtask

    task automatic check_result();
        frame_res_t got;
        frame_res_t want;
        got = make_res(m_tuser[1:0], m_tdata[7:0], m_tdata[15:8], m_tdata[23:16],
                       m_tdata[28:24], m_tuser[2], m_tdata[32:29], m_tdata[48:33], m_tlast);
        if (results_due.size() == 0) begin
            report_mismatch("result with nothing pending", got.status, 0);
            return;
        end
        want = results_due.pop_front();
        results_checked++;
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
        if (got.kind !== want.kind) report_mismatch("frame_kind", got.kind, want.kind);
        if (got.seq !== want.seq) report_mismatch("sequence_res", got.seq, want.seq);
        if (got.flags !== want.flags) report_mismatch("flag_bits", got.flags, want.flags);
        if (got.count !== want.count) report_mismatch("word_count", got.count, want.count);
        if (got.has !== want.has) report_mismatch("has_word", got.has, want.has);
        if (got.idx !== want.idx) report_mismatch("word_index", got.idx, want.idx);
        if (got.value !== want.value) report_mismatch("word_value", got.value, want.value);
        if (got.last !== want.last) report_mismatch("last", got.last, want.last);
    endtask

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_fire = 0;
        end else begin
            s_fire = s_tvalid && s_tready;
            if (m_tvalid && m_tready) check_result();
            if (s_fire) begin
                deframe_byte(s_tdata, s_tuser[0], s_tlast);
                bytes_taken++;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (aresetn && !(s_tvalid && s_tready) && !(m_tvalid && m_tready)) begin
            quiet_cycles++;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("no request moved for %0d cycles", QUIET_LIMIT);
                $display("[rc_frame_crc8_deframer] ERROR");
                $finish;
            end
        end else begin
            quiet_cycles = 0;
        end
    end

    // driver
    always @(negedge aclk) begin
        rx_item_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_fire) begin
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (rx_due.size() > 0) begin
                it = rx_due.pop_front();
                s_tdata <= it.data;
                s_tuser <= it.start;
                s_tlast <= it.fin;
                s_tvalid <= 1'b1;
                send_gap = steady ? 0 : pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                m_tready <= 1'b0;
            end else begin
                if (!steady && $urandom_range(0, 4) == 0) rx_stall = pick_gap();
                m_tready <= (rx_stall == 0);
                if (rx_stall > 0) rx_stall--;
            end
        end
    end

    task automatic push_rx(input logic [7:0] data, input logic start, input logic fin);
        rx_item_t it;
        it.data = data;
        it.start = start;
        it.fin = fin;
        rx_due.push_back(it);
        bytes_queued++;
    endtask

    // cut >= 0 stops the frame after that byte, with tlast set when cut_fin
    task automatic queue_frame(input logic [7:0] magic, input logic [7:0] kind,
                               input logic [7:0] seq, input logic [7:0] flags,
                               input int cnt, input bit bad_crc, input int cut,
                               input bit cut_fin, input bit fin_on_crc);
        logic [7:0]  fb[$];
        logic [7:0]  c;
        logic [15:0] w;
        int          r;
        fb.push_back(magic);
        fb.push_back(kind);
        fb.push_back(seq);
        fb.push_back(flags);
        fb.push_back(8'(cnt));
        for (int k = 0; k < cnt; k++) begin
            r = $urandom_range(0, 9);
            w = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom);
            fb.push_back(w[7:0]);
            fb.push_back(w[15:8]);
        end
        c = '0;
        for (int k = 0; k < fb.size(); k++) c = crc_after(c, fb[k]);
        if (bad_crc) c = c ^ 8'($urandom_range(1, 255));
        fb.push_back(c);
        for (int k = 0; k < fb.size(); k++) begin
            framed_bytes++;
            if (k == cut) begin
                push_rx(fb[k], k == 0, cut_fin);
                break;
            end
            push_rx(fb[k], k == 0, (k == fb.size() - 1) && fin_on_crc);
        end
        frames_built++;
    endtask

    task automatic random_frame();
        int         r;
        int         lim;
        int         cnt;
        int         cut;
        bit         cut_fin;
        logic [7:0] magic;
        logic [7:0] kind;
        lim = eff_limit();
        r = $urandom_range(0, 99);
        if (r < 8) begin
            // stray bytes, mostly ignored
            repeat ($urandom_range(1, 4)) begin
                push_rx(8'($urandom), $urandom_range(0, 9) == 0, 1'($urandom_range(0, 1)));
            end
            return;
        end
        magic = ($urandom_range(0, 99) < 92) ? cfg_magic : 8'($urandom);
        r = $urandom_range(0, 99);
        if (r < 30) kind = cfg_type_ct;
        else if (r < 60) kind = cfg_type_st;
        else if (r < 88) kind = cfg_type_pr;
        else kind = 8'($urandom);
        r = $urandom_range(0, 99);
        if (r < 55) cnt = $urandom_range(0, 3);
        else if (r < 75) cnt = $urandom_range(0, lim);
        else if (r < 88) cnt = lim + $urandom_range(0, 1);
        else if (r < 96) cnt = $urandom_range(16, 17);
        else cnt = $urandom_range(18, 40);
        cut = -1;
        cut_fin = 0;
        r = $urandom_range(0, 99);
        if (r < 12) begin
            cut = $urandom_range(0, rcfd_pkg::HEADER_BYTES - 1 + 2 * cnt);
            cut_fin = (r < 8);
        end
        queue_frame(magic, kind, 8'($urandom), 8'($urandom), cnt,
                    $urandom_range(0, 99) < 6, cut, cut_fin, $urandom_range(0, 2) == 0);
    endtask

    task automatic run_random(input int n);
        int first;
        first = framed_bytes;
        while (framed_bytes - first < n) random_frame();
    endtask

    task automatic settle();
        do @(negedge aclk); while (bytes_taken != bytes_queued || results_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic set_reg(input logic [2:0] idx, input logic [7:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            rcfd_pkg::CFG_MAGIC:   cfg_magic = val;
            rcfd_pkg::CFG_TYPE_CT: cfg_type_ct = val;
            rcfd_pkg::CFG_TYPE_ST: cfg_type_st = val;
            rcfd_pkg::CFG_TYPE_PR: cfg_type_pr = val;
            rcfd_pkg::CFG_LIMIT:   cfg_limit = val[4:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [7:0] magic, input logic [7:0] ct,
                                input logic [7:0] st, input logic [7:0] pr,
                                input logic [7:0] lim);
        set_reg(rcfd_pkg::CFG_MAGIC, magic);
        set_reg(rcfd_pkg::CFG_TYPE_CT, ct);
        set_reg(rcfd_pkg::CFG_TYPE_ST, st);
        set_reg(rcfd_pkg::CFG_TYPE_PR, pr);
        set_reg(rcfd_pkg::CFG_LIMIT, lim);
    endtask

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // stray byte while idle, then directed frames under reset registers
        push_rx(8'hFF, 1'b0, 1'b1);
        queue_frame(8'h00, 8'h00, 8'h00, 8'h00, 0, 0, -1, 0, 1);
        queue_frame(8'h00, 8'h02, 8'hFF, 8'hFF, 1, 0, -1, 0, 0);
        queue_frame(8'h00, 8'h01, 8'h5A, 8'hA5, 0, 1, -1, 0, 0);
        queue_frame(8'h00, 8'h01, 8'h11, 8'h22, 2, 0, 1, 1, 0);
        queue_frame(8'h00, 8'h01, 8'h33, 8'h44, 3, 0, 1, 0, 0);
        queue_frame(8'h00, 8'h03, 8'h80, 8'h01, 0, 0, -1, 0, 0);
        settle();

        program_regs(8'hA5, 8'h10, 8'h20, 8'h30, 8'd16);
        hold_req++;
        run_random(90);
        settle();

        program_regs(8'hFF, 8'hFF, 8'h00, 8'h80, 8'd0);
        run_random(90);
        settle();

        steady = 1;
        program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'd31);
        run_random(90);
        settle();
        steady = 0;

        program_regs(8'h00, 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom_range(1, 15)));
        run_random(90);
        settle();

        $display("sent %0d bytes in %0d frames over five register settings",
                 bytes_queued, frames_built);
        $display("checked %0d results, %0d mismatches", results_checked, errors);
        if (errors == 0) begin
            $display("[rc_frame_crc8_deframer] OK");
        end else begin
            $display("[rc_frame_crc8_deframer] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/rcfd_pkg.sv
src/rcfd_ram.sv
src/rcfd_ctrl.sv
src/rcfd_datapath.sv
src/rc_frame_crc8_deframer.sv
dv/rc_frame_crc8_deframer_test.sv
